// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRFA_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRFA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/frfa_pkg.sv -----
// ----------------------------------------------------------------------------
// First-fit region allocator package
// Field widths, transfer layouts and status codes of the allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frfa_pkg;

   localparam int SIZE_W     = 13;
   localparam int OFF_W      = 12;
   localparam int STAT_W     = 2;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;
   localparam int GRAN_SHIFT = 3;
   localparam int NEED_W     = SIZE_W - GRAN_SHIFT;
   localparam int TGT_W      = OFF_W - GRAN_SHIFT;

   typedef logic [STAT_W-1:0] status_type;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_BAD_SIZE  = 2'd1;
   localparam status_type ST_NO_SPACE  = 2'd2;
   localparam status_type ST_NOT_FOUND = 2'd3;

endpackage

// ----- rtl/frfa_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/first_fit_region_allocator_core.sv -----
// ----------------------------------------------------------------------------
// First-fit region allocator core
// Manages one region in 8-byte units as a chain of free and taken blocks.
// ----------------------------------------------------------------------------
// The req_ channel carries allocate and free requests, one transfer each;
// req_tuser selects the kind. Every request yields exactly one rsp_ transfer
// with the granted offset and a status code.
// One entry per unit is kept in a single RAM holding a taken flag and the
// length of the block starting there. A request walks the chain from unit 0,
// one block per cycle. A granted allocate, or a free of a taken block, then
// passes through the write states S_WR_A, S_WR_B and S_WR_C to S_OUT,
// which loads the output register; a rejected size goes from idle straight
// to S_OUT. req_tready is low for the whole of a request.
// After reset a clearing pass writes every RAM entry, one per cycle, before
// the first request is taken.
// The result sits in an output register; a new request may be taken while it
// waits, and a following result is held until rsp_tready frees the register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module first_fit_region_allocator_core
   import frfa_pkg::*;
#(
   parameter int REGION_BYTES = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // req_size, free_offset, zero fill
   input  logic                  req_tuser,  // kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // alloc_offset, status, zero fill
);

   localparam int UNITS = REGION_BYTES >> GRAN_SHIFT;
   localparam int UW    = $clog2(UNITS);
   localparam int LW    = $clog2(UNITS + 1);
   localparam int CW    = ((LW > NEED_W) ? LW : NEED_W) + 1;
   localparam int EW    = LW + 1;

   localparam logic [CW-1:0] UNITS_C = CW'(UNITS);
   localparam logic [UW-1:0] LAST_U  = UW'(UNITS - 1);

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_AWALK = 4'd2;
   localparam logic [3:0] S_FWALK = 4'd3;
   localparam logic [3:0] S_FNXT  = 4'd4;
   localparam logic [3:0] S_WR_A  = 4'd5;
   localparam logic [3:0] S_WR_B  = 4'd6;
   localparam logic [3:0] S_WR_C  = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   logic [3:0]            state_ff, state_in;
   logic [UW-1:0]         clr_ff, clr_in;
   logic [UW-1:0]         cur_ff, cur_in;
   logic [TGT_W-1:0]      tgt_ff, tgt_in;
   logic [NEED_W-1:0]     need_ff, need_in;
   logic [UW-1:0]         prev_ff, prev_in;
   logic                  prev_taken_ff, prev_taken_in;
   logic [LW-1:0]         prev_len_ff, prev_len_in;
   logic                  has_prev_ff, has_prev_in;
   logic [LW-1:0]         cur_len_ff, cur_len_in;
   logic [UW-1:0]         aux_ff, aux_in;
   logic                  aux_en_ff, aux_en_in;
   logic [LW-1:0]         aux_len_ff, aux_len_in;
   logic [EW-1:0]         wb_data_ff, wb_data_in;
   logic                  wc_en_ff, wc_en_in;
   logic [LW-1:0]         wc_len_ff, wc_len_in;
   status_type            st_ff, st_in;
   logic [OFF_W-1:0]      off_ff, off_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [SIZE_W-1:0] req_size;
   logic [OFF_W-1:0]  free_offset;
   logic              req_fire;
   logic              ram_we;
   logic [UW-1:0]     ram_waddr;
   logic [EW-1:0]     ram_wdata;
   logic [UW-1:0]     ram_raddr;
   logic [EW-1:0]     ram_rdata;
   logic              rd_taken;
   logic [LW-1:0]     rd_len;
   logic [CW-1:0]     step_sum;
   logic [CW-1:0]     split_sum;
   logic              finalize;
   logic [LW-1:0]     fin_len;
   logic              merge_prev;

   assign req_size    = req_tdata[SIZE_W-1:0];
   assign free_offset = req_tdata[SIZE_W+OFF_W-1:SIZE_W];
   assign req_tready  = (state_ff == S_IDLE);
   assign req_fire    = req_tvalid && req_tready;

   assign rd_taken   = ram_rdata[LW];
   assign rd_len     = (ram_rdata[LW-1:0] == '0) ? LW'(1) : ram_rdata[LW-1:0];
   assign step_sum   = CW'(cur_ff) + CW'(rd_len);
   assign split_sum  = CW'(cur_ff) + CW'(need_ff);
   assign merge_prev = has_prev_ff && !prev_taken_ff;

   frfa_ram #(
      .WIDTH (EW),
      .DEPTH (UNITS)
   ) u_chain_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = cur_ff;
      ram_wdata = wb_data_ff;
      case (state_ff)
         S_CLR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = (clr_ff == '0) ? {1'b0, LW'(UNITS)} : '0;
         end
         S_WR_A: begin
            ram_we    = aux_en_ff;
            ram_waddr = aux_ff;
            ram_wdata = {1'b0, aux_len_ff};
         end
         S_WR_B: begin
            ram_we    = 1'b1;
         end
         S_WR_C: begin
            ram_we    = wc_en_ff;
            ram_waddr = prev_ff;
            ram_wdata = {1'b0, wc_len_ff};
         end
         default: begin
            ram_we    = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      tgt_in        = tgt_ff;
      need_in       = need_ff;
      prev_in       = prev_ff;
      prev_taken_in = prev_taken_ff;
      prev_len_in   = prev_len_ff;
      has_prev_in   = has_prev_ff;
      cur_len_in    = cur_len_ff;
      aux_in        = aux_ff;
      aux_en_in     = aux_en_ff;
      aux_len_in    = aux_len_ff;
      wb_data_in    = wb_data_ff;
      wc_en_in      = wc_en_ff;
      wc_len_in     = wc_len_ff;
      st_in         = st_ff;
      off_in        = off_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      ram_raddr     = cur_ff;
      finalize      = 1'b0;
      fin_len       = cur_len_ff;

      case (state_ff)
         S_CLR: begin
            clr_in = clr_ff + UW'(1);
            if (clr_ff == LAST_U) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            ram_raddr = '0;
            if (req_fire) begin
               cur_in      = '0;
               off_in      = '0;
               has_prev_in = 1'b0;
               aux_en_in   = 1'b0;
               wc_en_in    = 1'b0;
               if (req_tuser == KIND_ALLOC) begin
                  if (req_size == '0 || req_size[GRAN_SHIFT-1:0] != '0) begin
                     st_in    = ST_BAD_SIZE;
                     state_in = S_OUT;
                  end else begin
                     need_in  = req_size[SIZE_W-1:GRAN_SHIFT];
                     state_in = S_AWALK;
                  end
               end else begin
                  if (free_offset[GRAN_SHIFT-1:0] != '0 ||
                      CW'(free_offset[OFF_W-1:GRAN_SHIFT]) >= UNITS_C) begin
                     st_in    = ST_NOT_FOUND;
                     state_in = S_OUT;
                  end else begin
                     tgt_in   = free_offset[OFF_W-1:GRAN_SHIFT];
                     state_in = S_FWALK;
                  end
               end
            end
         end
         S_AWALK: begin
            if (!rd_taken && CW'(rd_len) >= CW'(need_ff)) begin
               aux_in     = UW'(split_sum);
               aux_en_in  = (CW'(rd_len) > CW'(need_ff)) && (split_sum < UNITS_C);
               aux_len_in = LW'(CW'(rd_len) - CW'(need_ff));
               wb_data_in = {1'b1, LW'(need_ff)};
               off_in     = OFF_W'({cur_ff, {GRAN_SHIFT{1'b0}}});
               wc_en_in   = 1'b0;
               st_in      = ST_OK;
               state_in   = S_WR_A;
            end else if (step_sum >= UNITS_C) begin
               st_in    = ST_NO_SPACE;
               state_in = S_OUT;
            end else begin
               cur_in    = UW'(step_sum);
               ram_raddr = UW'(step_sum);
            end
         end
         S_FWALK: begin
            if (CW'(cur_ff) == CW'(tgt_ff)) begin
               if (!rd_taken) begin
                  st_in    = ST_OK;
                  state_in = S_OUT;
               end else begin
                  cur_len_in = rd_len;
                  if (step_sum < UNITS_C) begin
                     aux_in    = UW'(step_sum);
                     ram_raddr = UW'(step_sum);
                     state_in  = S_FNXT;
                  end else begin
                     finalize = 1'b1;
                     fin_len  = rd_len;
                  end
               end
            end else if (CW'(cur_ff) > CW'(tgt_ff) || step_sum >= UNITS_C) begin
               st_in    = ST_NOT_FOUND;
               state_in = S_OUT;
            end else begin
               prev_in       = cur_ff;
               prev_taken_in = rd_taken;
               prev_len_in   = rd_len;
               has_prev_in   = 1'b1;
               cur_in        = UW'(step_sum);
               ram_raddr     = UW'(step_sum);
            end
         end
         S_FNXT: begin
            aux_en_in  = !rd_taken;
            aux_len_in = '0;
            finalize   = 1'b1;
            fin_len    = rd_taken ? cur_len_ff : LW'(CW'(cur_len_ff) + CW'(rd_len));
         end
         S_WR_A: begin
            state_in = S_WR_B;
         end
         S_WR_B: begin
            state_in = S_WR_C;
         end
         S_WR_C: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({st_ff, off_ff});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finalize) begin
         wb_data_in = {1'b0, merge_prev ? LW'(0) : fin_len};
         wc_en_in   = merge_prev;
         wc_len_in  = LW'(CW'(prev_len_ff) + CW'(fin_len));
         st_in      = ST_OK;
         state_in   = S_WR_A;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      tgt_ff        <= tgt_in;
      need_ff       <= need_in;
      prev_ff       <= prev_in;
      prev_taken_ff <= prev_taken_in;
      prev_len_ff   <= prev_len_in;
      has_prev_ff   <= has_prev_in;
      cur_len_ff    <= cur_len_in;
      aux_ff        <= aux_in;
      aux_en_ff     <= aux_en_in;
      aux_len_ff    <= aux_len_in;
      wb_data_ff    <= wb_data_in;
      wc_en_ff      <= wc_en_in;
      wc_len_ff     <= wc_len_in;
      st_ff         <= st_in;
      off_ff        <= off_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `FRFA_ASSERT_NEXT(a_busy_after_accept, req_fire, state_ff != S_IDLE,
      "Request transfer did not start a walk")
   `FRFA_ASSERT_SAME(a_offset_zero_on_error,
      rsp_valid_ff && rsp_data_ff[OFF_W+STAT_W-1:OFF_W] != ST_OK,
      rsp_data_ff[OFF_W-1:0] == '0, "Failed request reports a non-zero offset")
   `FRFA_ASSERT_SAME(a_write_in_write_state, ram_we,
      state_ff == S_CLR || state_ff == S_WR_A || state_ff == S_WR_B || state_ff == S_WR_C,
      "Chain RAM written outside a write state")

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// First-fit region allocator testbench
// Drives allocate and free requests into the allocator core and predicts
// every reply from a private copy of the unit chain. Replies are checked in
// order, field by field, under random idling on both sides, a long receiver
// hold-off, a drained pause and a final stretch at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import frfa_pkg::*;

   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 7;
   localparam int REGION         = 4096;
   localparam int UNITS          = REGION >> GRAN_SHIFT;
   localparam int LEN_W          = 10;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = UNITS + 16;
   localparam int HOLD_OFF       = 300;
   localparam int FILL_W         = REQ_DATA_W - SIZE_W - OFF_W;

   typedef struct packed {
      logic [OFF_W-1:0] offset;
      status_type       status;
   } alloc_reply_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // req_size, free_offset, zero fill
   logic                  req_tuser;   // kind
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // alloc_offset, status, zero fill

   logic             unit_busy [UNITS];
   logic [LEN_W-1:0] run_len [UNITS];

   alloc_reply_type  owed_replies [$];
   logic [OFF_W-1:0] live_blocks [$];
   logic [OFF_W-1:0] released_offsets [$];

   bit idling_on     = 1'b1;
   int hold_off_left = 0;
   int rsp_gap_left  = 0;
   int quiet_cycles  = 0;
   int error_count   = 0;
   int allocs_sent   = 0;
   int frees_sent    = 0;
   int status_seen [4] = '{0, 0, 0, 0};

   first_fit_region_allocator_core #(
      .REGION_BYTES(REGION)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic int run_span(int u);
      return (run_len[u] == 0) ? 1 : int'(run_len[u]);
   endfunction

   function automatic alloc_reply_type first_fit_take(logic [SIZE_W-1:0] size);
      alloc_reply_type r;
      int need;
      int u;
      int span;
      r.offset = '0;
      r.status = ST_BAD_SIZE;
      if (size == 0 || size[GRAN_SHIFT-1:0] != 0) return r;
      need = int'(size) >> GRAN_SHIFT;
      r.status = ST_NO_SPACE;
      u = 0;
      while (u < UNITS) begin
         span = run_span(u);
         if (!unit_busy[u] && span >= need) begin
            if (span > need && u + need < UNITS) begin
               run_len[u + need] = LEN_W'(span - need);
               unit_busy[u + need] = 1'b0;
            end
            run_len[u] = LEN_W'(need);
            unit_busy[u] = 1'b1;
            r.offset = OFF_W'(u << GRAN_SHIFT);
            r.status = ST_OK;
            return r;
         end
         u += span;
      end
      return r;
   endfunction

   function automatic status_type coalesce_free(logic [OFF_W-1:0] off);
      int target;
      int u;
      int prev;
      int nxt;
      bit has_prev;
      if (off[GRAN_SHIFT-1:0] != 0) return ST_NOT_FOUND;
      target = int'(off) >> GRAN_SHIFT;
      u = 0;
      prev = 0;
      has_prev = 1'b0;
      while (u < UNITS && u != target) begin
         if (u > target) return ST_NOT_FOUND;
         prev = u;
         has_prev = 1'b1;
         u += run_span(u);
      end
      if (u != target) return ST_NOT_FOUND;
      if (!unit_busy[u]) return ST_OK;
      unit_busy[u] = 1'b0;
      nxt = u + run_span(u);
      if (nxt < UNITS && !unit_busy[nxt]) begin
         run_len[u] = LEN_W'(run_span(u) + run_span(nxt));
         run_len[nxt] = '0;
      end
      if (has_prev && !unit_busy[prev]) begin
         run_len[prev] = LEN_W'(run_span(prev) + run_span(u));
         run_len[u] = '0;
      end
      return ST_OK;
   endfunction

   task automatic send_request(input logic kind, input logic [SIZE_W-1:0] size,
                               input logic [OFF_W-1:0] off);
      alloc_reply_type r;
      @(negedge clock);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{FILL_W{1'b0}}, off, size};
      do @(posedge clock); while (!req_tready);
      if (kind == KIND_ALLOC) begin
         r = first_fit_take(size);
         allocs_sent++;
         if (r.status == ST_OK) live_blocks.push_back(r.offset);
      end else begin
         r.offset = '0;
         r.status = coalesce_free(off);
         frees_sent++;
         foreach (live_blocks[i]) begin
            if (r.status == ST_OK && live_blocks[i] == off) begin
               live_blocks.delete(i);
               released_offsets.push_back(off);
               if (released_offsets.size() > 32) void'(released_offsets.pop_front());
               break;
            end
         end
      end
      owed_replies.push_back(r);
   endtask

   task automatic send_random_item();
      logic [SIZE_W-1:0] size;
      logic [OFF_W-1:0]  off;
      int                free_bias;
      int                pick;
      size = SIZE_W'($urandom_range(0, 8191));
      off  = OFF_W'($urandom_range(0, 4095));
      free_bias = (live_blocks.size() == 0) ? 1 : (live_blocks.size() > 24 ? 7 : 4);
      if ($urandom_range(0, 9) < free_bias) begin
         pick = $urandom_range(0, 9);
         if (pick < 7 && live_blocks.size() > 0)
            off = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
         else if (pick < 9 && released_offsets.size() > 0)
            off = released_offsets[$urandom_range(0, released_offsets.size() - 1)];
         send_request(KIND_FREE, size, off);
      end else begin
         case ($urandom_range(0, 19))
            0:       size = '0;
            1:       size = SIZE_W'(($urandom_range(0, 1023) << GRAN_SHIFT)
                                    | $urandom_range(1, 7));
            2:       size = SIZE_W'($urandom_range(0, 8191));
            3, 4:    size = SIZE_W'($urandom_range(1, UNITS) << GRAN_SHIFT);
            default: size = SIZE_W'($urandom_range(1, 16) << GRAN_SHIFT);
         endcase
         send_request(KIND_ALLOC, size, off);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (owed_replies.size() != 0) @(posedge clock);
   endtask

   task automatic test_edge_cases();
      send_request(KIND_ALLOC, 13'd0,    12'd0);
      send_request(KIND_ALLOC, 13'd1,    12'd4095);
      send_request(KIND_ALLOC, 13'd8191, 12'd0);
      send_request(KIND_ALLOC, 13'd8184, 12'd2730);
      send_request(KIND_ALLOC, 13'd4096, 12'd0);
      send_request(KIND_ALLOC, 13'd8,    12'd0);
      send_request(KIND_FREE,  13'd0,    12'd4);
      send_request(KIND_FREE,  13'd0,    12'd4095);
      send_request(KIND_FREE,  13'd0,    12'd8);
      send_request(KIND_FREE,  13'd8191, 12'd0);
      send_request(KIND_FREE,  13'd5461, 12'd0);
      send_request(KIND_ALLOC, 13'd64,   12'd1365);
      send_request(KIND_ALLOC, 13'd128,  12'd0);
      send_request(KIND_ALLOC, 13'd8,    12'd0);
      send_request(KIND_ALLOC, 13'd3896, 12'd0);
      send_request(KIND_FREE,  13'd0,    12'd64);
      send_request(KIND_FREE,  13'd0,    12'd200);
      send_request(KIND_ALLOC, 13'd64,   12'd0);
      send_request(KIND_FREE,  13'd0,    12'd0);
      send_request(KIND_FREE,  13'd0,    12'd192);
      send_request(KIND_FREE,  13'd0,    12'd64);
      send_request(KIND_ALLOC, 13'd4088, 12'd0);
      send_request(KIND_ALLOC, 13'd8,    12'd0);
      send_request(KIND_FREE,  13'd0,    12'd4088);
      send_request(KIND_FREE,  13'd0,    12'd0);
   endtask

   task automatic test_random_mix(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 150 == 0) idling_on = ($urandom_range(0, 3) != 0);
         send_random_item();
      end
      idling_on = 1'b1;
   endtask

   task automatic test_receiver_hold_off();
      hold_off_left = HOLD_OFF;
      for (int i = 0; i < 30; i++) send_random_item();
   endtask

   task automatic test_drained_pause();
      wait_drained();
      for (int i = 0; i < 100; i++) send_random_item();
   endtask

   task automatic test_full_rate();
      idling_on = 1'b0;
      for (int i = 0; i < 115; i++) send_random_item();
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_tready <= 1'b0;
            hold_off_left--;
         end else if (rsp_gap_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_gap_left--;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            rsp_gap_left = $urandom_range(0, 15);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      alloc_reply_type  want;
      logic [OFF_W-1:0] got_offset;
      status_type       got_status;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_offset = rsp_tdata[OFF_W-1:0];
         got_status = rsp_tdata[OFF_W+STAT_W-1:OFF_W];
         status_seen[got_status]++;
         if (owed_replies.size() == 0) begin
            error_count++;
            $display("%0t: unexpected reply, offset %0d status %0d", $time,
                     got_offset, got_status);
         end else begin
            want = owed_replies.pop_front();
            if (got_offset !== want.offset) begin
               error_count++;
               $display("%0t: offset mismatch, expected %0d, actual %0d", $time,
                        want.offset, got_offset);
            end
            if (got_status !== want.status) begin
               error_count++;
               $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                        want.status, got_status);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = KIND_ALLOC;
      req_tdata  = '0;
      for (int u = 0; u < UNITS; u++) begin
         unit_busy[u] = 1'b0;
         run_len[u]   = '0;
      end
      run_len[0] = LEN_W'(UNITS);
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      test_edge_cases();
      test_random_mix(900);
      test_receiver_hold_off();
      test_drained_pause();
      test_full_rate();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d allocate, %0d free, %0d mismatches.",
               allocs_sent + frees_sent, allocs_sent, frees_sent, error_count);
      $display("Replies seen: ok %0d, bad size %0d, no space %0d, not found %0d.",
               status_seen[ST_OK], status_seen[ST_BAD_SIZE],
               status_seen[ST_NO_SPACE], status_seen[ST_NOT_FOUND]);
      if (error_count == 0 && owed_replies.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/frfa_pkg.sv
rtl/frfa_ram.sv
rtl/first_fit_region_allocator_core.sv
tb/testbench.sv
